// ----- rtl/fcdm_pkg.sv -----
package fcdm_pkg;

  typedef struct packed {
    logic [63:0] a_real;
    logic [63:0] a_imag;
    logic [63:0] b_real;
    logic [63:0] b_imag;
  } in_item_t;

  typedef struct packed {
    logic [63:0] real_product;
    logic [63:0] imag_product;
    logic        range_error;
  } out_item_t;

  // operands plus zero class per operand (a_real, a_imag, b_real, b_imag)
  typedef struct packed {
    in_item_t   item;
    logic [3:0] is_zero;
  } work_t;

  // m * 2^e, m normalized to bit 63 when nonzero, bit 0 sticky
  typedef struct packed {
    logic [63:0]        m;
    logic signed [13:0] e;
    logic               s;
  } xnum_t;

  localparam logic [10:0]        EXP_MASK    = 11'h7FF;
  localparam logic signed [13:0] PROD_BIAS   = 14'sd2150;
  localparam logic signed [13:0] RND_BIAS    = 14'sd1086;
  localparam logic signed [13:0] EXP_MAX_FLD = 14'sd2046;
  localparam logic [7:0]         RND_SEL     = 8'hC8;

endpackage

// ----- rtl/fcdm_front.sv -----
module fcdm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  fcdm_pkg::in_item_t operands,
  output logic              stg_valid,
  output fcdm_pkg::work_t   stg_work,
  input  logic              stg_take
);
  import fcdm_pkg::*;

  logic accept;

  assign full   = stg_valid && !stg_take;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (stg_take) begin
      stg_valid <= 1'b0;
    end
  end

  // zero or subnormal operands count as zero
  always_ff @(posedge clk) begin
    if (accept) begin
      stg_work.item       <= operands;
      stg_work.is_zero[3] <= operands.a_real[62:52] == '0;
      stg_work.is_zero[2] <= operands.a_imag[62:52] == '0;
      stg_work.is_zero[1] <= operands.b_real[62:52] == '0;
      stg_work.is_zero[0] <= operands.b_imag[62:52] == '0;
    end
  end

endmodule

// ----- rtl/fcdm_queue.sv -----
module fcdm_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  fcdm_pkg::work_t wr_data,
  output logic            q_full,
  output logic            q_valid,
  output fcdm_pkg::work_t rd_data,
  input  logic            rd_en
);
  import fcdm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  work_t           slots [DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign q_full  = count == CW'(DEPTH);
  assign q_valid = count != '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

// ----- rtl/fcdm_back.sv -----
module fcdm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  fcdm_pkg::work_t     q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output fcdm_pkg::out_item_t result
);
  import fcdm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_FIN  = 7'b0000100,
    S_ADD  = 7'b0001000,
    S_NORM = 7'b0010000,
    S_RND  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t        state;
  work_t         work;
  logic [1:0]    pidx;
  logic [1:0]    kidx;
  logic          part;
  logic [105:0]  acc;
  xnum_t         prod [4];
  xnum_t         z;
  logic [63:0]   res_re;
  logic [63:0]   res_im;
  logic          rng;
  logic          ovalid;

  // operand pair for current product
  logic [63:0]   opx;
  logic [63:0]   opy;
  logic          zx;
  logic          zy;
  logic [52:0]   mx;
  logic [52:0]   my;
  logic [26:0]   px;
  logic [26:0]   py;
  logic [53:0]   pp;
  logic [105:0]  pp_sh;

  always_comb begin
    unique case (pidx)
      2'd0: begin
        opx = work.item.a_real; opy = work.item.b_real;
        zx = work.is_zero[3];   zy = work.is_zero[1];
      end
      2'd1: begin
        opx = work.item.a_imag; opy = work.item.b_imag;
        zx = work.is_zero[2];   zy = work.is_zero[0];
      end
      2'd2: begin
        opx = work.item.a_real; opy = work.item.b_imag;
        zx = work.is_zero[3];   zy = work.is_zero[0];
      end
      default: begin
        opx = work.item.a_imag; opy = work.item.b_real;
        zx = work.is_zero[2];   zy = work.is_zero[1];
      end
    endcase
    mx = {1'b1, opx[51:0]};
    my = {1'b1, opy[51:0]};
    px = kidx[1] ? {1'b0, mx[52:27]} : mx[26:0];
    py = kidx[0] ? {1'b0, my[52:27]} : my[26:0];
    pp = px * py;
    unique case (kidx)
      2'd0:    pp_sh = {52'd0, pp};
      2'd3:    pp_sh = {pp[51:0], 54'd0};
      default: pp_sh = {25'd0, pp, 27'd0};
    endcase
  end

  // product reduction to 64-bit mantissa with sticky
  xnum_t fin;
  always_comb begin
    fin.s = opx[63] ^ opy[63] ^ (pidx == 2'd1);
    if (acc[105]) begin
      fin.m = acc[105:42] | {63'd0, |acc[41:0]};
      fin.e = 14'(opx[62:52]) + 14'(opy[62:52]) - PROD_BIAS + 14'sd42;
    end else begin
      fin.m = acc[104:41] | {63'd0, |acc[40:0]};
      fin.e = 14'(opx[62:52]) + 14'(opy[62:52]) - PROD_BIAS + 14'sd41;
    end
    if (zx || zy) begin
      fin.m = '0;
      fin.e = '0;
    end
  end

  // aligned add of one pair
  xnum_t         ax;
  xnum_t         ay;
  xnum_t         hi;
  xnum_t         lo;
  xnum_t         sum_z;
  logic          sum_norm;
  logic signed [13:0] dexp;
  logic [63:0]   bm;
  logic [64:0]   s65;
  logic [63:0]   dif;

  always_comb begin
    ax = part ? prod[2] : prod[0];
    ay = part ? prod[3] : prod[1];
    if (ax.e < ay.e || (ax.e == ay.e && ax.m < ay.m)) begin
      hi = ay; lo = ax;
    end else begin
      hi = ax; lo = ay;
    end
    dexp = hi.e - lo.e;
    if (|dexp[13:6]) begin
      bm = 64'd1;
    end else begin
      bm = (lo.m >> dexp[5:0])
         | {63'd0, (lo.m & ((64'd1 << dexp[5:0]) - 64'd1)) != '0};
    end
    s65 = {1'b0, hi.m} + {1'b0, bm};
    dif = hi.m - bm;
    sum_norm = 1'b0;
    sum_z    = hi;
    priority if (ax.m == '0 && ay.m == '0) begin
      sum_z.m = '0;
      sum_z.e = '0;
      sum_z.s = ax.s & ay.s;
    end else if (ax.m == '0) begin
      sum_z = ay;
    end else if (ay.m == '0) begin
      sum_z = ax;
    end else if (hi.s == lo.s) begin
      if (s65[64]) begin
        sum_z.m = {1'b1, s65[63:1]} | {63'd0, s65[0]};
        sum_z.e = hi.e + 14'sd1;
      end else begin
        sum_z.m = s65[63:0];
      end
    end else if (dif == '0) begin
      sum_z.m = '0;
      sum_z.e = '0;
      sum_z.s = 1'b0;
    end else begin
      sum_z.m  = dif;
      sum_norm = 1'b1;
    end
  end

  // single rounding to nearest-even
  logic [54:0]        m55;
  logic [53:0]        mant;
  logic signed [13:0] ef;
  logic [63:0]        rnd_val;
  logic               rnd_rng;

  always_comb begin
    m55  = z.m[63:9] | {54'd0, |z.m[8:0]};
    mant = {1'b0, m55[54:2]} + {53'd0, RND_SEL[m55[2:0]]};
    ef   = z.e + RND_BIAS + {13'd0, mant[53]};
    rnd_rng = 1'b0;
    priority if (z.m == '0) begin
      rnd_val = {z.s, 63'd0};
    end else if (ef > EXP_MAX_FLD) begin
      rnd_val = {z.s, EXP_MASK, 52'd0};
      rnd_rng = 1'b1;
    end else if (ef < 14'sd1) begin
      rnd_val = {z.s, 63'd0};
      rnd_rng = 1'b1;
    end else begin
      rnd_val = {z.s, ef[10:0], mant[51:0]};
    end
  end

  assign q_pop = (state == S_IDLE) && q_valid;
  assign empty = !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
      pidx   <= '0;
      kidx   <= '0;
      part   <= 1'b0;
    end else begin
      // load and drain of the output register in one place
      if (state == S_DONE && (!ovalid || pop)) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            pidx  <= '0;
            kidx  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          kidx <= kidx + 1'b1;
          if (kidx == 2'd3) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          pidx <= pidx + 1'b1;
          if (pidx == 2'd3) begin
            part  <= 1'b0;
            state <= S_ADD;
          end else begin
            state <= S_MUL;
          end
        end
        S_ADD: begin
          state <= sum_norm ? S_NORM : S_RND;
        end
        S_NORM: begin
          if (z.m[63]) begin
            state <= S_RND;
          end
        end
        S_RND: begin
          if (part) begin
            state <= S_DONE;
          end else begin
            part  <= 1'b1;
            state <= S_ADD;
          end
        end
        S_DONE: begin
          if (!ovalid || pop) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work <= q_data;
    end
    if (state == S_MUL) begin
      acc <= (kidx == 2'd0) ? pp_sh : acc + pp_sh;
    end
    if (state == S_FIN) begin
      prod[pidx] <= fin;
    end
    if (state == S_ADD) begin
      z <= sum_z;
    end
    if (state == S_NORM && !z.m[63]) begin
      if (z.m[63:56] == '0) begin
        z.m <= z.m << 8;
        z.e <= z.e - 14'sd8;
      end else begin
        z.m <= z.m << 1;
        z.e <= z.e - 14'sd1;
      end
    end
    if (state == S_RND) begin
      if (part) begin
        res_im <= rnd_val;
        rng    <= rng | rnd_rng;
      end else begin
        res_re <= rnd_val;
        rng    <= rnd_rng;
      end
    end
    if (state == S_DONE && (!ovalid || pop)) begin
      result.real_product <= res_re;
      result.imag_product <= res_im;
      result.range_error  <= rng;
    end
  end

endmodule

// ----- rtl/fused_complex_double_multiply_unit.sv -----
// Fused complex multiply of two complex doubles.
// Input channel: push/full. A beat carries a_real, a_imag, b_real, b_imag
//   (raw double bits) and is taken on a clock edge with push high, full low.
// Result channel: empty/pop. While empty is low the oldest result beat
//   (real_product, imag_product, range_error) sits on result; it leaves on
//   an edge with pop high.
// Structure: a front stage registers each beat and marks zero/subnormal
//   operands; a queue of QUEUE_DEPTH entries decouples it from the back end.
// Back end: an idle/fetch state, then one shared 27x27 multiplier forms each
//   53x53 product from four partial products plus a reduce step, then per
//   part an align/add step, optional normalize steps (shift by 8 or by 1,
//   the last one sees bit 63 set) and a round step, then a step to load
//   the result.
// Sequencing: the back end fetches the next item from the queue only in its
//   idle state, after the previous result has moved to the output register;
//   the shared multiplier and the iterative normalizer set the rate.
// Reset (rst, synchronous): all queues and the result register empty.
// Receiver stall: a finished result waits in the output register; the back
//   end holds the next one, the queue fills, and then full rises.
module fused_complex_double_multiply_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  fcdm_pkg::in_item_t  operands,
  output logic                empty,
  input  logic                pop,
  output fcdm_pkg::out_item_t result
);
  import fcdm_pkg::*;

  logic  stg_valid;
  work_t stg_work;
  logic  q_full;
  logic  q_valid;
  work_t q_data;
  logic  q_pop;

  fcdm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operands  (operands),
    .stg_valid (stg_valid),
    .stg_work  (stg_work),
    .stg_take  (!q_full)
  );

  fcdm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (stg_valid),
    .wr_data (stg_work),
    .q_full  (q_full),
    .q_valid (q_valid),
    .rd_data (q_data),
    .rd_en   (q_pop)
  );

  fcdm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ----- rtl/fcdm_checker.sv -----
module fcdm_checker (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input fcdm_pkg::out_item_t result
);
  import fcdm_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result not empty after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

  a_no_inf_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.range_error) |->
      (result.real_product[62:52] != EXP_MASK &&
       result.imag_product[62:52] != EXP_MASK))
    else $error("max exponent without range flag");

  a_range_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.range_error) |->
      (result.real_product[62:52] == EXP_MASK ||
       result.imag_product[62:52] == EXP_MASK ||
       result.real_product[62:0] == '0 ||
       result.imag_product[62:0] == '0))
    else $error("range flag with ordinary results");

endmodule

bind fused_complex_double_multiply_unit fcdm_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
